### src/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear Bayer demosaic: pixel, window
// column, color codes, register indexes, request actions and the color
// filter site table.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int CSR_ADDR_W = 4;

   typedef logic [7:0] pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // index 0 left, 1 center, 2 right
   typedef column_type [2:0] window_type;

   typedef struct packed {
      pixel_type red;
      pixel_type green;
      pixel_type blue;
   } rgb_type;

   typedef struct packed {
      logic       x_odd;
      logic       y_odd;
      logic [1:0] cfa;
   } site_type;

   typedef enum logic [1:0] {
      COLOUR_RED   = 2'd0,
      COLOUR_GREEN = 2'd1,
      COLOUR_BLUE  = 2'd2
   } colour_type;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_CFA_PATTERN  = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_DRAIN = 1'b1
   } action_type;

   // [cfa order][{row odd, column odd}]
   localparam colour_type SITE_TABLE [4][4] = '{
      '{COLOUR_RED,   COLOUR_GREEN, COLOUR_GREEN, COLOUR_BLUE},
      '{COLOUR_GREEN, COLOUR_RED,   COLOUR_BLUE,  COLOUR_GREEN},
      '{COLOUR_GREEN, COLOUR_BLUE,  COLOUR_RED,   COLOUR_GREEN},
      '{COLOUR_BLUE,  COLOUR_GREEN, COLOUR_GREEN, COLOUR_RED}
   };

endpackage

### src/bbd_if.sv
// ----------------------------------------------------------------------------
// bbd_req_if / bbd_rsp_if
// Valid/ready channels of the demosaic: raw pixel requests in, RGB out.
// ----------------------------------------------------------------------------
interface bbd_req_if import bbd_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      action;
   pixel_type pixel_value;

   modport source (output valid, output action, output pixel_value, input ready);
   modport sink (input valid, input action, input pixel_value, output ready);
endinterface

interface bbd_rsp_if import bbd_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type red;
   pixel_type green;
   pixel_type blue;
   logic      last_of_frame;

   modport source (output valid, output red, output green, output blue,
                   output last_of_frame, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input last_of_frame, output ready);
endinterface

### src/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear colour reconstruction of one site from its 3x3 neighborhood.
// ----------------------------------------------------------------------------
module bbd_interp import bbd_pkg::*; (
   input  window_type nbhd,
   input  site_type   site,
   output rgb_type    rgb
);

   pixel_type  self_px;
   pixel_type  up_px;
   pixel_type  down_px;
   pixel_type  left_px;
   pixel_type  right_px;
   logic [9:0] cross_sum;
   logic [9:0] diag_sum;
   logic [8:0] horiz_sum;
   logic [8:0] vert_sum;
   pixel_type  cross_avg;
   pixel_type  diag_avg;
   pixel_type  horiz_avg;
   pixel_type  vert_avg;
   colour_type here_colour;
   colour_type beside_colour;

   assign self_px  = nbhd[1].mid;
   assign up_px    = nbhd[1].top;
   assign down_px  = nbhd[1].bot;
   assign left_px  = nbhd[0].mid;
   assign right_px = nbhd[2].mid;

   assign cross_sum = 10'(left_px) + 10'(right_px) + 10'(up_px) + 10'(down_px) + 10'd2;
   assign diag_sum  = 10'(nbhd[0].top) + 10'(nbhd[2].top) + 10'(nbhd[0].bot)
                    + 10'(nbhd[2].bot) + 10'd2;
   assign horiz_sum = 9'(left_px) + 9'(right_px) + 9'd1;
   assign vert_sum  = 9'(up_px) + 9'(down_px) + 9'd1;

   assign cross_avg = cross_sum[9:2];
   assign diag_avg  = diag_sum[9:2];
   assign horiz_avg = horiz_sum[8:1];
   assign vert_avg  = vert_sum[8:1];

   assign here_colour   = SITE_TABLE[site.cfa][{site.y_odd, site.x_odd}];
   assign beside_colour = SITE_TABLE[site.cfa][{site.y_odd, ~site.x_odd}];

   always_comb begin
      case (here_colour)
         COLOUR_RED: begin
            rgb.red   = self_px;
            rgb.green = cross_avg;
            rgb.blue  = diag_avg;
         end
         COLOUR_BLUE: begin
            rgb.red   = diag_avg;
            rgb.green = cross_avg;
            rgb.blue  = self_px;
         end
         default: begin
            rgb.green = self_px;
            if (beside_colour == COLOUR_RED) begin
               rgb.red  = horiz_avg;
               rgb.blue = vert_avg;
            end else begin
               rgb.red  = vert_avg;
               rgb.blue = horiz_avg;
            end
         end
      endcase
   end

endmodule

### src/bilinear_bayer_demosaic.sv
// ----------------------------------------------------------------------------
// bilinear_bayer_demosaic
// Streaming bilinear Bayer demosaic with two line stores in one memory and
// a 3x3 window register.
//
//   channel   direction   handshake      payload
//   req       in          valid/ready    action, pixel_value
//   rsp       out         valid/ready    red, green, blue, last_of_frame
//   csr       in/out      apb write      frame_width, frame_height, cfa_pattern
//
// one request per clock; a request is taken while stage one is empty or leaving
// the line memory read issued at acceptance feeds stage one, which updates the
// window, interpolates and loads the result register when it moves on
// a stalled result holds an emitting stage one request, and that holds req
// synchronous reset clears control and window; the line memory is not cleared
// ----------------------------------------------------------------------------
module bilinear_bayer_demosaic import bbd_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   bbd_req_if.sink               req,
   bbd_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int LEN_W = COL_W + 1;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   // configuration
   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic [1:0]  cfa_ff;
   logic        csr_wr;
   reg_index_type csr_index;
   logic        geo_wr;
   logic [LEN_W-1:0] used_w;
   logic [11:0] used_h;

   // input side
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [12:0]      in_row_ff, in_row_in;
   logic             accept;
   logic             in_frame;
   logic             at_tail;
   logic             at_final;
   logic             drain_ignored;
   logic             step;
   logic             final_step;
   logic             in_col_last;

   // line memory
   line_pair_type line_ram [MAX_WIDTH];
   line_pair_type rd_data_ff;

   // stage one
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_final_ff;
   logic             s1_first_ff;
   logic             s1_emit_ff;
   logic             s1_top_ff;
   logic             s1_bottom_ff;
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic             s1_go;
   column_type       new_col;
   window_type       win_ff;
   window_type       nbhd;
   rgb_type          rgb;

   // output side
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [11:0]      out_row_ff, out_row_in;
   logic             out_last;
   logic             rsp_valid_ff, rsp_valid_in;
   rgb_type          rsp_rgb_ff;
   logic             rsp_last_ff;

   // ---------------- configuration port
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);
   assign geo_wr    = csr_wr && (csr_index == REG_FRAME_WIDTH ||
                                 csr_index == REG_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 12'd480;
         cfa_ff    <= 2'd0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= pwdata[11:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[11:0];
            REG_CFA_PATTERN:  cfa_ff    <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FRAME_WIDTH:  prdata = 32'(width_ff);
         REG_FRAME_HEIGHT: prdata = 32'(height_ff);
         REG_CFA_PATTERN:  prdata = 32'(cfa_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         used_w = LEN_W'(MAX_WIDTH);
      end else if (width_ff < 12'd2) begin
         used_w = LEN_W'(2);
      end else begin
         used_w = LEN_W'(width_ff);
      end
   end

   assign used_h = (height_ff < 12'd2) ? 12'd2 : height_ff;

   // ---------------- input side
   assign accept        = req.valid && req.ready;
   assign in_frame      = in_row_ff < {1'b0, used_h};
   assign at_tail       = in_row_ff == {1'b0, used_h};
   assign at_final      = in_row_ff > {1'b0, used_h};
   assign drain_ignored = in_frame && (req.action == ACTION_DRAIN);
   assign step          = accept && !drain_ignored && !at_final;
   assign final_step    = accept && at_final;
   assign in_col_last   = ({1'b0, in_col_ff} + LEN_W'(1)) == used_w;

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (geo_wr || final_step) begin
         in_col_in = '0;
         in_row_in = '0;
      end else if (step) begin
         if (in_col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 13'd1;
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
      end
   end

   // ---------------- line memory: read at request, write back in stage one
   always_ff @(posedge clock) begin
      if (step) begin
         rd_data_ff <= line_ram[in_col_ff];
      end
      if (s1_go && !s1_final_ff && !s1_bottom_ff) begin
         line_ram[s1_addr_ff] <= '{upper: rd_data_ff.middle, middle: s1_pixel_ff};
      end
   end

   // ---------------- stage one
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req.ready) begin
         s1_valid_in = step || final_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_final_ff  <= at_final;
         s1_first_ff  <= in_col_ff == '0;
         s1_emit_ff   <= at_final || ((in_col_ff == '0) ? (in_row_ff >= 13'd2)
                                                        : (in_row_ff >= 13'd1));
         s1_top_ff    <= in_row_ff == 13'd1;
         s1_bottom_ff <= at_tail;
         s1_pixel_ff  <= req.pixel_value;
         s1_addr_ff   <= in_col_ff;
      end
   end

   assign new_col.mid = rd_data_ff.middle;
   assign new_col.top = s1_top_ff ? rd_data_ff.middle : rd_data_ff.upper;
   assign new_col.bot = s1_bottom_ff ? rd_data_ff.middle : s1_pixel_ff;

   assign nbhd[0] = win_ff[1];
   assign nbhd[1] = win_ff[2];
   assign nbhd[2] = (s1_final_ff || s1_first_ff) ? win_ff[2] : new_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go && !s1_final_ff) begin
         if (s1_first_ff) begin
            win_ff <= {new_col, new_col, new_col};
         end else begin
            win_ff <= {new_col, win_ff[2], win_ff[1]};
         end
      end
   end

   bbd_interp u_interp (
      .nbhd (nbhd),
      .site ('{x_odd: out_col_ff[0], y_odd: out_row_ff[0], cfa: cfa_ff}),
      .rgb  (rgb)
   );

   // ---------------- output side
   assign out_last = ({1'b0, out_col_ff} == used_w - LEN_W'(1))
                  && (out_row_ff == used_h - 12'd1);

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (geo_wr) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (s1_go && s1_emit_ff) begin
         if (({1'b0, out_col_ff} + LEN_W'(1)) == used_w) begin
            out_col_in = '0;
            out_row_in = (out_row_ff + 12'd1 == used_h) ? 12'd0 : out_row_ff + 12'd1;
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_rgb_ff  <= rgb;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.red           = rsp_rgb_ff.red;
   assign rsp.green         = rsp_rgb_ff.green;
   assign rsp.blue          = rsp_rgb_ff.blue;
   assign rsp.last_of_frame = rsp_last_ff;

endmodule

### src/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks of the demosaic, bound to the top level.
// ----------------------------------------------------------------------------
module bbd_checker import bbd_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input pixel_type rsp_red,
   input pixel_type rsp_green,
   input pixel_type rsp_blue,
   input logic      rsp_last_of_frame
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
                                  && $stable(rsp_blue) && $stable(rsp_last_of_frame))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result follows an accepted request, through stage one and the result register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without request");

   // empty result register never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

endmodule

bind bilinear_bayer_demosaic bbd_checker u_bbd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_red           (rsp.red),
   .rsp_green         (rsp.green),
   .rsp_blue          (rsp.blue),
   .rsp_last_of_frame (rsp.last_of_frame)
);
